// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the thumb16 encoder modules
// expects clk and rst_n in the enclosing module
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every rising clock edge outside reset
`define T16E_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// same-cycle implication checked outside reset
`define T16E_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/t16e_pkg.sv
// ---------------------------------------------------------------------------
// t16e_pkg
// types, opcodes and encoding helpers of the thumb16 instruction encoder
// ---------------------------------------------------------------------------
package t16e_pkg;

    localparam int CMD_W  = 4;
    localparam int REGD_W = 4;
    localparam int REGN_W = 3;
    localparam int REGM_W = 4;
    localparam int IMM_W  = 32;
    localparam int HW_W   = 16;

    // queue between classifier and sequencer
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // sequencer step index, up to seven halfwords
    localparam int STEP_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADDS       = 4'd0,
        CMD_ADDS_IMM   = 4'd1,
        CMD_SUBS       = 4'd2,
        CMD_SUBS_IMM   = 4'd3,
        CMD_MOV_IMM    = 4'd4,
        CMD_MOV_REG    = 4'd5,
        CMD_LSLS_IMM   = 4'd6,
        CMD_LSLS_REG   = 4'd7,
        CMD_ANDS       = 4'd8,
        CMD_STR        = 4'd9,
        CMD_STRH       = 4'd10,
        CMD_STRB       = 4'd11,
        CMD_LDR        = 4'd12,
        CMD_LDRH       = 4'd13,
        CMD_LDRB       = 4'd14,
        CMD_LOAD_CONST = 4'd15
    } cmd_t;

    localparam logic [6:0] OPC_ADDS     = 7'b0001100;
    localparam logic [6:0] OPC_SUBS     = 7'b0001101;
    localparam logic [4:0] OPC_ADDS_IMM = 5'b00110;
    localparam logic [4:0] OPC_SUBS_IMM = 5'b00111;
    localparam logic [4:0] OPC_MOV_IMM  = 5'b00100;
    localparam logic [7:0] OPC_MOV_REG  = 8'b01000110;
    localparam logic [4:0] OPC_LSLS_IMM = 5'b00000;
    localparam logic [9:0] OPC_LSLS_REG = 10'b0100000010;
    localparam logic [9:0] OPC_ANDS     = 10'b0100000000;
    localparam logic [4:0] OPC_STR      = 5'b01100;
    localparam logic [4:0] OPC_STRH     = 5'b10000;
    localparam logic [4:0] OPC_STRB     = 5'b01110;
    localparam logic [4:0] OPC_LDR      = 5'b01101;
    localparam logic [4:0] OPC_LDRH     = 5'b10001;
    localparam logic [4:0] OPC_LDRB     = 5'b01111;

    // shift amount of the lsls between constant bytes
    localparam logic [4:0] LC_SHIFT = 5'd8;

    // classified item as held in the queue
    typedef struct packed {
        logic             is_lc;     // load constant, sequenced in the back end
        logic [HW_W-1:0]  hw;        // finished halfword of a single command
        logic [2:0]       rd;        // load constant target
        logic [IMM_W-1:0] imm;       // load constant value
        logic [1:0]       top_byte;  // index of the highest nonzero byte
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [HW_W-1:0] enc_three_reg(
        input logic [6:0] opc, input logic [2:0] rd,
        input logic [2:0] rn, input logic [2:0] rm);
        return {opc, rm, rn, rd};
    endfunction

    function automatic logic [HW_W-1:0] enc_imm8(
        input logic [4:0] opc, input logic [2:0] rdn, input logic [7:0] imm);
        return {opc, rdn, imm};
    endfunction

    function automatic logic [HW_W-1:0] enc_imm5(
        input logic [4:0] opc, input logic [2:0] rt,
        input logic [2:0] rn, input logic [4:0] imm);
        return {opc, imm, rn, rt};
    endfunction

    function automatic logic [HW_W-1:0] enc_two_reg(
        input logic [9:0] opc, input logic [2:0] rdn, input logic [2:0] rm);
        return {opc, rm, rdn};
    endfunction

endpackage

// File: rtl/core/t16e_if.sv
// ---------------------------------------------------------------------------
// t16e channel interfaces
// valid/ready channels for commands in and halfwords out
// ---------------------------------------------------------------------------
interface t16e_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [t16e_pkg::CMD_W-1:0]    command;
    logic [t16e_pkg::REGD_W-1:0]   reg_d;
    logic [t16e_pkg::REGN_W-1:0]   reg_n;
    logic [t16e_pkg::REGM_W-1:0]   reg_m;
    logic [t16e_pkg::IMM_W-1:0]    immediate;

    modport source (output valid, command, reg_d, reg_n, reg_m, immediate, input ready);
    modport sink   (input valid, command, reg_d, reg_n, reg_m, immediate, output ready);
endinterface

interface t16e_hw_if;
    logic                        valid;
    logic                        ready;
    logic [t16e_pkg::HW_W-1:0]   instr_halfword;
    logic                        last;

    modport source (output valid, instr_halfword, last, input ready);
    modport sink   (input valid, instr_halfword, last, output ready);
endinterface

// File: rtl/core/t16e_front.sv
// ---------------------------------------------------------------------------
// t16e_front
// accepts commands, encodes single-halfword forms, sizes load constants
// ---------------------------------------------------------------------------
module t16e_front (
    t16e_cmd_if.sink               cmd_bus,
    input  t16e_pkg::qstat_t       qstat,
    output logic                   push,
    output t16e_pkg::q_entry_t     push_data
);
    import t16e_pkg::*;

    cmd_t       cmd;
    logic [2:0] rd;
    logic [2:0] rn;
    logic [2:0] rm;
    logic [7:0] imm8;
    logic [4:0] imm5;

    assign cmd  = cmd_t'(cmd_bus.command);
    assign rd   = cmd_bus.reg_d[2:0];
    assign rn   = cmd_bus.reg_n;
    assign rm   = cmd_bus.reg_m[2:0];
    assign imm8 = cmd_bus.immediate[7:0];
    assign imm5 = cmd_bus.immediate[4:0];

    assign cmd_bus.ready = !qstat.full;
    assign push          = cmd_bus.valid && !qstat.full;

    always_comb
    begin
        push_data       = '0;
        push_data.rd    = rd;
        push_data.imm   = cmd_bus.immediate;
        push_data.is_lc = (cmd == CMD_LOAD_CONST);

        unique case (cmd)
            CMD_ADDS:       push_data.hw = enc_three_reg(OPC_ADDS, rd, rn, rm);
            CMD_ADDS_IMM:   push_data.hw = enc_imm8(OPC_ADDS_IMM, rd, imm8);
            CMD_SUBS:       push_data.hw = enc_three_reg(OPC_SUBS, rd, rn, rm);
            CMD_SUBS_IMM:   push_data.hw = enc_imm8(OPC_SUBS_IMM, rd, imm8);
            CMD_MOV_IMM:    push_data.hw = enc_imm8(OPC_MOV_IMM, rd, imm8);
            CMD_MOV_REG:    push_data.hw = {OPC_MOV_REG, cmd_bus.reg_d[3],
                                            cmd_bus.reg_m, rd};
            CMD_LSLS_IMM:   push_data.hw = enc_imm5(OPC_LSLS_IMM, rd, rm, imm5);
            CMD_LSLS_REG:   push_data.hw = enc_two_reg(OPC_LSLS_REG, rd, rm);
            CMD_ANDS:       push_data.hw = enc_two_reg(OPC_ANDS, rd, rm);
            CMD_STR:        push_data.hw = enc_imm5(OPC_STR, rd, rn, imm5);
            CMD_STRH:       push_data.hw = enc_imm5(OPC_STRH, rd, rn, imm5);
            CMD_STRB:       push_data.hw = enc_imm5(OPC_STRB, rd, rn, imm5);
            CMD_LDR:        push_data.hw = enc_imm5(OPC_LDR, rd, rn, imm5);
            CMD_LDRH:       push_data.hw = enc_imm5(OPC_LDRH, rd, rn, imm5);
            CMD_LDRB:       push_data.hw = enc_imm5(OPC_LDRB, rd, rn, imm5);
            CMD_LOAD_CONST: push_data.hw = '0;
            default:        push_data.hw = '0;
        endcase

        // highest nonzero byte sets the halfword count
        priority if (cmd_bus.immediate[31:24] != 8'd0)
            push_data.top_byte = 2'd3;
        else if (cmd_bus.immediate[23:16] != 8'd0)
            push_data.top_byte = 2'd2;
        else if (cmd_bus.immediate[15:8] != 8'd0)
            push_data.top_byte = 2'd1;
        else
            push_data.top_byte = 2'd0;
    end

endmodule

// File: rtl/core/t16e_queue.sv
// ---------------------------------------------------------------------------
// t16e_queue
// short fifo of classified items between front and back end
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module t16e_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  t16e_pkg::q_entry_t     push_data,
    input  logic                   pop,
    output t16e_pkg::q_entry_t     head,
    output t16e_pkg::qstat_t       qstat
);
    import t16e_pkg::*;

    q_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `T16E_CHECK(a_count_bound, count_reg <= QCNT_W'(QDEPTH), "queue count over depth")
    `T16E_IMPLIES(a_ptr_gap, !qstat.full && !qstat.empty,
                  wr_ptr_reg != rd_ptr_reg, "queue pointers disagree with count")

endmodule

// File: rtl/core/t16e_back.sv
// ---------------------------------------------------------------------------
// t16e_back
// sequences halfwords of the head item into the output register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module t16e_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  t16e_pkg::q_entry_t     head,
    input  t16e_pkg::qstat_t       qstat,
    output logic                   pop,
    t16e_hw_if.source              hw_bus
);
    import t16e_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [HW_W-1:0]   hw_reg;
    logic [HW_W-1:0]   hw_next;
    logic              last_reg;
    logic              last_next;

    logic              head_valid;
    logic              advance;
    logic              step_last;
    logic [1:0]        byte_idx;
    logic [7:0]        cur_byte;

    assign head_valid = !qstat.empty;
    assign advance    = head_valid && (!out_valid_reg || hw_bus.ready);

    // last halfword of a load constant sits at step 2 * top_byte
    assign step_last = (step_reg == {head.top_byte, 1'b0});
    assign byte_idx  = head.top_byte - step_reg[2:1];
    assign cur_byte  = head.imm[{byte_idx, 3'b000} +: 8];

    always_comb
    begin
        priority if (!head.is_lc)
            hw_next = head.hw;
        else if (step_reg == '0)
            hw_next = enc_imm8(OPC_MOV_IMM, head.rd, cur_byte);
        else if (step_reg[0])
            hw_next = enc_imm5(OPC_LSLS_IMM, head.rd, head.rd, LC_SHIFT);
        else
            hw_next = enc_imm8(OPC_ADDS_IMM, head.rd, cur_byte);

        last_next = !head.is_lc || step_last;
        pop       = advance && last_next;

        if (advance)
            step_next = last_next ? '0 : step_reg + 1'b1;
        else
            step_next = step_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (hw_bus.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hw_reg   <= hw_next;
            last_reg <= last_next;
        end
    end

    assign hw_bus.valid          = out_valid_reg;
    assign hw_bus.instr_halfword = hw_reg;
    assign hw_bus.last           = last_reg;

    `T16E_IMPLIES(a_step_owner, step_reg != '0, head_valid && head.is_lc,
                  "sequencer mid-item without a load constant at the head")
    `T16E_IMPLIES(a_step_bound, head_valid && head.is_lc,
                  step_reg <= {head.top_byte, 1'b0}, "sequencer ran past last halfword")

endmodule

// File: rtl/core/thumb16_instruction_encoder.sv
// ---------------------------------------------------------------------------
// thumb16_instruction_encoder
// encodes commands into 16-bit thumb halfwords, load constant into several
// ---------------------------------------------------------------------------
// latency: a command is written into the queue, then its halfword into the output register, where it becomes valid
// throughput: one halfword per cycle on hw_bus while hw_bus.ready stays high, set by the back-end sequencer
// a load constant takes 1, 3, 5 or 7 halfwords from the sequencer, others one
// the two-entry queue keeps taking commands while the sequencer works, as long as it has room
// reset: asynchronous, active low, empties queue, sequencer and output stage

module thumb16_instruction_encoder (
    input  logic         clk,
    input  logic         rst_n,
    t16e_cmd_if.sink     cmd_bus,
    t16e_hw_if.source    hw_bus
);
    import t16e_pkg::*;

    // front end to queue
    logic     push;
    q_entry_t push_data;

    // queue to back end
    logic     pop;
    q_entry_t head;
    qstat_t   qstat;

    // classifier: accepts a command whenever the queue has room and encodes
    // every single-halfword form right away
    t16e_front u_front (
        .cmd_bus   (cmd_bus),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // decouples acceptance from output backpressure
    t16e_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    // sequencer: emits the head item's halfwords into the output register,
    // mov then lsls/adds pairs for a load constant
    t16e_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .hw_bus (hw_bus)
    );

endmodule
